FILE: hw/rtl/button_debounce_hold_timer_top_assert.svh
// Assertion macros shared by the RTL of the button debouncer.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef BUTTON_DEBOUNCE_HOLD_TIMER_TOP_ASSERT_SVH
`define BUTTON_DEBOUNCE_HOLD_TIMER_TOP_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is high.
`define BDHT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("debouncer check failed");

// Next-cycle implication, disabled while reset is high.
`define BDHT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("debouncer check failed");

`else

`define BDHT_ASSERT_NOW(label, clk, rst, ante, cons)
`define BDHT_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

FILE: hw/rtl/bdht_pkg.sv
package bdht_pkg;

   // Field widths fixed by the interface.
   localparam int DEBOUNCE_WIDTH   = 16;
   localparam int COUNT_WIDTH      = 16;
   localparam int OUT_TIME_WIDTH   = 32;

   // Default width of the internal tick arithmetic.
   localparam int TIME_BITS_DEFAULT = 32;

   // Settle window after reset, in ticks.
   localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 16'd25;

   // The pin is active low.
   localparam logic PIN_PRESSED = 1'b0;

   typedef struct packed {
      logic pin_level;
      logic take_release;
   } req_type;

   typedef struct packed {
      logic                      is_down;
      logic [OUT_TIME_WIDTH-1:0] held_time;
      logic [COUNT_WIDTH-1:0]    press_total;
      logic                      release_valid;
      logic [OUT_TIME_WIDTH-1:0] release_duration;
   } rsp_type;

endpackage

FILE: hw/rtl/button_debounce_hold_timer_top.sv
// Button debouncer with hold timer and press counter.
//
// Each transfer on the req_ channel is one millisecond tick carrying the raw,
// active-low pin level and a request to consume a pending release. Each
// request gives exactly one transfer on the rsp_ channel with the debounced
// level, the live held time, the press count and any release consumed.
// The csr_ channel writes the settle window in ticks; it is always ready
// and is meant to be written only while no tick is in flight.
//
// A request transfer passes through the input register and then the result
// register before its response transfer; while the receiver stalls a full
// result register, the tick waits in the input register. A new tick is taken
// in every cycle unless req_stall is high, so throughput is one tick per cycle;
// the state update of one tick is two increments, three subtractions and three
// compares between the input and result registers.
//
// Reset (synchronous, active high) empties both registers, clears all tick
// state and loads the settle window with 25. When the receiver stalls, the
// result is held and one further request is still taken into the input
// register; only when both are full is req_stall raised.
module button_debounce_hold_timer_top
   import bdht_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,

   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_type                   req_data,

   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_type                   rsp_data,

   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [DEBOUNCE_WIDTH-1:0] csr_data
);

`include "button_debounce_hold_timer_top_assert.svh"

   // Configuration register.
   logic [DEBOUNCE_WIDTH-1:0] settle_win_ff;

   // Input register.
   logic    in_valid_ff, in_valid_in;
   req_type in_ff;

   // Result register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Tick state.
   logic                   started_ff, started_in;
   logic [TIME_BITS-1:0]   tick_now_ff, tick_now_in;
   logic                   last_raw_ff, last_raw_in;
   logic                   stable_ff, stable_in;
   logic [TIME_BITS-1:0]   change_time_ff, change_time_in;
   logic [TIME_BITS-1:0]   press_start_ff, press_start_in;
   logic [COUNT_WIDTH-1:0] press_count_ff, press_count_in;
   logic                   pending_ff, pending_in;
   logic [TIME_BITS-1:0]   hold_length_ff, hold_length_in;

   logic                   out_ready;
   logic                   advance;
   logic                   req_accept;
   logic                   raw;
   logic [TIME_BITS-1:0]   settle_time;
   logic [TIME_BITS-1:0]   held;

   // The result register can take a new value when it is empty or being read.
   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign advance    = in_valid_ff && out_ready;
   assign req_stall  = in_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   assign in_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // The pin reads pressed when it is low.
   assign raw = (in_ff.pin_level == PIN_PRESSED);

   always_comb begin
      started_in     = started_ff;
      tick_now_in    = tick_now_ff;
      last_raw_in    = last_raw_ff;
      stable_in      = stable_ff;
      change_time_in = change_time_ff;
      press_start_in = press_start_ff;
      press_count_in = press_count_ff;
      pending_in     = pending_ff;
      hold_length_in = hold_length_ff;
      settle_time    = '0;
      held           = '0;
      rsp_in         = '0;

      if (!started_ff) begin
         // The first tick seeds the levels from the pin without debouncing.
         started_in     = 1'b1;
         change_time_in = tick_now_ff;
         last_raw_in    = raw;
         stable_in      = raw;
         if (raw) begin
            press_start_in = tick_now_ff;
         end
      end else begin
         tick_now_in = tick_now_ff + TIME_BITS'(1);
         settle_time = tick_now_in - change_time_ff;
         if (raw != last_raw_ff) begin
            // Any change of the raw level restarts the settle window.
            last_raw_in    = raw;
            change_time_in = tick_now_in;
         end else if ((raw != stable_ff) &&
                      (settle_time >= TIME_BITS'(settle_win_ff))) begin
            stable_in = raw;
            if (raw) begin
               press_start_in = tick_now_in;
               press_count_in = press_count_ff + COUNT_WIDTH'(1);
            end else begin
               hold_length_in = tick_now_in - press_start_ff;
               pending_in     = 1'b1;
            end
         end
      end

      if (stable_in) begin
         held = tick_now_in - press_start_in;
      end

      rsp_in.is_down     = stable_in;
      rsp_in.held_time   = OUT_TIME_WIDTH'(held);
      rsp_in.press_total = press_count_in;

      // A release latched on this tick may be consumed by the same tick.
      if (in_ff.take_release && pending_in) begin
         pending_in              = 1'b0;
         rsp_in.release_valid    = 1'b1;
         rsp_in.release_duration = OUT_TIME_WIDTH'(hold_length_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         settle_win_ff  <= DEBOUNCE_RESET;
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         started_ff     <= 1'b0;
         tick_now_ff    <= '0;
         last_raw_ff    <= 1'b0;
         stable_ff      <= 1'b0;
         change_time_ff <= '0;
         press_start_ff <= '0;
         press_count_ff <= '0;
         pending_ff     <= 1'b0;
         hold_length_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            settle_win_ff <= csr_data;
         end
         if (advance) begin
            started_ff     <= started_in;
            tick_now_ff    <= tick_now_in;
            last_raw_ff    <= last_raw_in;
            stable_ff      <= stable_in;
            change_time_ff <= change_time_in;
            press_start_ff <= press_start_in;
            press_count_ff <= press_count_in;
            pending_ff     <= pending_in;
            hold_length_ff <= hold_length_in;
         end
      end
   end

   // Payload registers need no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // A request is never taken into a full input register that is not moving on.
   `BDHT_ASSERT_NOW(a_no_overwrite, clock, reset,
      req_valid && !req_stall, !in_valid_ff || advance)

   // The press count only moves on a debounced press.
   `BDHT_ASSERT_NOW(a_count_on_press, clock, reset,
      advance && (press_count_in != press_count_ff), stable_in && !stable_ff)

   // A consumed release must have been asked for by the same tick.
   `BDHT_ASSERT_NOW(a_release_asked, clock, reset,
      advance && rsp_in.release_valid, in_ff.take_release)

   // A tick that moves on shows up in the result register next cycle.
   `BDHT_ASSERT_NEXT(a_result_loaded, clock, reset, advance, rsp_valid_ff)

   // The held time is zero while the button is up.
   `BDHT_ASSERT_NOW(a_held_zero_up, clock, reset,
      rsp_valid_ff && !rsp_ff.is_down, rsp_ff.held_time == '0)

endmodule
